/* rtl/core/rtdavg_pkg.sv */
// ----------------------------------------------------------------------------
// rtdavg_pkg
// Shared types and constants of the RTD temperature converter and averager.
// ----------------------------------------------------------------------------
package rtdavg_pkg;

	localparam int TEMP_W      = 16;
	localparam int CFG_W       = 24;
	localparam int CFG_IDX_W   = 3;
	localparam int ALU_W       = 44;
	localparam int MUL_A_W     = 25;
	localparam int MUL_B_W     = 18;
	localparam int PROD_W      = MUL_A_W + MUL_B_W;
	localparam int DIF_W       = 18;
	localparam int QUO_W       = 17;
	localparam int DSH_W       = QUO_W + QUO_W - 1;
	localparam int STEP_W      = 5;
	localparam int AVG_FRAC_W  = 23;
	localparam int AVG_SPLIT_W = 12;

	localparam logic [15:0] FS_RESET   = 16'd4096;
	localparam logic [23:0] OOA_RESET  = 24'd66496;
	localparam logic [7:0]  RMAX_RESET = 8'd100;
	localparam logic [7:0]  RMIN_RESET = 8'hD8;
	localparam logic signed [TEMP_W-1:0] AVG_RESET = -16'sd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_SCALE     = 3'd0,
		REG_ONE_OVER_ALPHA = 3'd1,
		REG_RANGE_MAX      = 3'd2,
		REG_RANGE_MIN      = 3'd3,
		REG_CYCLE_TEST     = 3'd4,
		REG_FAN_UNDER_TEST = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t                  op;
		logic signed [ALU_W-1:0]  a;
		logic signed [ALU_W-1:0]  b;
	} alu_req_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef enum logic [16:0] {
		ST_IDLE = 17'b00000000000000001,
		ST_DIFF = 17'b00000000000000010,
		ST_XM   = 17'b00000000000000100,
		ST_MN   = 17'b00000000000001000,
		ST_MH   = 17'b00000000000010000,
		ST_ML   = 17'b00000000000100000,
		ST_CH   = 17'b00000000001000000,
		ST_CL   = 17'b00000000010000000,
		ST_ABS  = 17'b00000000100000000,
		ST_DIV  = 17'b00000001000000000,
		ST_SGN  = 17'b00000010000000000,
		ST_UPD  = 17'b00000100000000000,
		ST_SUM  = 17'b00001000000000000,
		ST_OUT  = 17'b00010000000000000,
		ST_RCPH = 17'b00100000000000000,
		ST_RCPL = 17'b01000000000000000,
		ST_RCPS = 17'b10000000000000000
	} state_t;

endpackage

/* rtl/core/rtdavg_alu.sv */
// ----------------------------------------------------------------------------
// rtdavg_alu
// Shared wide adder/subtractor used by the sequencer steps that add or subtract.
// ----------------------------------------------------------------------------
module rtdavg_alu import rtdavg_pkg::*; (
	input  alu_req_t                req,
	output logic signed [ALU_W-1:0] y
);

	always_comb begin
		unique case (req.op)
			ALU_ADD: y = req.a + req.b;
			ALU_SUB: y = req.a - req.b;
		endcase
	end

endmodule

/* rtl/core/rtdavg_mul.sv */
// ----------------------------------------------------------------------------
// rtdavg_mul
// Signed 25x18 multiplier with a registered product.
// ----------------------------------------------------------------------------
module rtdavg_mul import rtdavg_pkg::*; (
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= req.a * req.b;
	end

	assign prod = prod_q;

endmodule

/* rtl/core/rtd_adc_to_temperature_averager_unit.sv */
// ----------------------------------------------------------------------------
// rtd_adc_to_temperature_averager_unit
// Converts RTD divider ADC counts to Q8.8 degrees, keeps one entry per
// channel and averages all entries once per round of NUM_CHANNELS items.
// ----------------------------------------------------------------------------
//  channel   | dir | transfer fields
//  s_*       | in  | tdata: channel_index, adc_count, onchip_temp, fan_index
//            |     | tuser: is_onchip
//  m_*       | out | tdata: channel_temp, average_temp
//            |     | tuser: measured, out_of_range, average_ready
//  cfg_*     | in  | cfg_index selects register, cfg_data is the value
//
//  on-chip item: update, output; RTD item first runs difference, multiplies, compares,
//  absolute value, divide and sign; a failed conversion skips to update
//  closing a round sums all entries; the 17-step restoring divide uses the shared
//  adder, the round mean a split reciprocal multiply on the shared multiplier
//  s_tready is high only while the sequencer is idle
//  a held result in the output register does not block the next accept
//  reset clears entries, marks, round count and sets the average to -1.0
// ----------------------------------------------------------------------------
module rtd_adc_to_temperature_averager_unit import rtdavg_pkg::*; #(
	parameter int NUM_CHANNELS = 4,
	parameter int ADC_BITS     = 12,
	localparam int IN_W        = 22 + ADC_BITS,
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// channel_index, adc_count, onchip_temp, fan_index, zero pad
	input  logic [IN_TDATA_W-1:0] s_tdata,
	// is_onchip
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// channel_temp, average_temp
	output logic [31:0]           m_tdata,
	// measured, out_of_range, average_ready
	output logic [2:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CHX_W = IDX_W + 2;

	// mean by reciprocal, 2^23 / NUM_CHANNELS rounded up, split at bit 12 into two parts
	localparam longint RCP_M = ((longint'(1) << AVG_FRAC_W) + longint'(NUM_CHANNELS) - 1)
		/ longint'(NUM_CHANNELS);
	localparam logic signed [MUL_B_W-1:0] RCP_HI = MUL_B_W'(RCP_M >> AVG_SPLIT_W);
	localparam logic signed [MUL_B_W-1:0] RCP_LO =
		MUL_B_W'(RCP_M & ((longint'(1) << AVG_SPLIT_W) - 1));

	state_t state_q, state_d;

	logic [15:0] fs_q;
	logic [23:0] ooa_q;
	logic [7:0]  rmax_q;
	logic [7:0]  rmin_q;
	logic        cte_q;
	logic [3:0]  fut_q;

	logic [1:0]               ch_q;
	logic [ADC_BITS-1:0]      adc_q;
	logic                     onchip_q;
	logic signed [TEMP_W-1:0] itemp_q;
	logic [3:0]               fan_q;

	logic signed [DIF_W-1:0]  d_q;
	logic signed [DIF_W-1:0]  x_q;
	logic signed [PROD_W-1:0] n_q;
	logic signed [PROD_W-1:0] hi_q;
	logic signed [PROD_W-1:0] lo_q;
	logic                     okhi_q;
	logic                     fail_q;
	logic signed [ALU_W-1:0]  rem_q;
	logic [DSH_W-1:0]         dsh_q;
	logic [QUO_W-1:0]         q_q;
	logic                     neg_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [TEMP_W-1:0] quot_q;

	logic signed [TEMP_W-1:0] store_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]  mark_q;
	logic [IDX_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         sum_idx_q;
	logic signed [TEMP_W-1:0] avg_reg_q;
	logic                     round_q;
	logic                     avg_mode_q;

	logic signed [TEMP_W-1:0] res_temp_q;
	logic                     res_mark_q;
	logic                     res_oor_q;

	logic                     m_tvalid_q;
	logic [31:0]              m_tdata_q;
	logic [2:0]               m_tuser_q;

	alu_req_t                 alu_req;
	logic signed [ALU_W-1:0]  alu_y;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] prod;

	logic signed [15:0]       rmax_sh;
	logic signed [15:0]       rmin_sh;
	logic [CHX_W-1:0]         ch_ext;
	logic [IDX_W-1:0]         ch_idx;
	logic [IDX_W-1:0]         rd_idx;
	logic signed [TEMP_W-1:0] rd_temp;
	logic                     rd_mark;
	logic                     stored;
	logic                     frozen;
	logic                     d_bad;
	logic                     fail_now;
	logic                     last_item;
	logic                     out_free;
	logic                     div_done;
	logic                     sum_done;
	logic signed [TEMP_W-1:0] upd_temp;
	logic                     upd_mark;
	logic                     upd_oor;
	logic                     in_xfer;

	assign in_xfer   = s_tvalid && s_tready;
	assign rmax_sh   = {rmax_q, 8'h00};
	assign rmin_sh   = {rmin_q, 8'h00};
	assign ch_ext    = CHX_W'(ch_q);
	assign ch_idx    = ch_ext[IDX_W-1:0];
	assign stored    = int'(ch_q) < NUM_CHANNELS;
	assign rd_idx    = (state_q == ST_SUM) ? sum_idx_q : ch_idx;
	assign rd_temp   = store_q[rd_idx];
	assign rd_mark   = mark_q[rd_idx];
	assign d_bad     = d_q[DIF_W-1] || (d_q == '0);
	assign fail_now  = d_bad || !okhi_q || alu_y[ALU_W-1];
	assign last_item = cnt_q == IDX_W'(NUM_CHANNELS - 1);
	assign sum_done  = sum_idx_q == IDX_W'(NUM_CHANNELS - 1);
	assign div_done  = step_q == STEP_W'(QUO_W - 1);
	assign out_free  = !m_tvalid_q || m_tready;
	assign frozen    = !onchip_q && cte_q && (fut_q != 4'd0) && (fan_q == fut_q - 4'd1);

	// entry and mark chosen for this item
	always_comb begin
		upd_oor = !onchip_q && fail_q;
		if (onchip_q || fail_q) begin
			upd_temp = itemp_q;
			upd_mark = 1'b0;
		end else begin
			upd_temp = quot_q;
			upd_mark = 1'b1;
		end
		if (frozen) begin
			upd_temp = stored ? rd_temp : '0;
			upd_mark = stored ? rd_mark : 1'b0;
		end
	end

	rtdavg_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	rtdavg_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	always_comb begin
		alu_req = '{op: ALU_ADD, a: '0, b: '0};
		mul_req = '{a: '0, b: '0};
		unique case (state_q)
			ST_DIFF: alu_req = '{op: ALU_SUB, a: ALU_W'(fs_q), b: ALU_W'(adc_q)};
			ST_XM:   alu_req = '{op: ALU_SUB, a: ALU_W'(adc_q), b: ALU_W'(d_q)};
			ST_MN:   mul_req = '{a: MUL_A_W'(ooa_q), b: x_q};
			ST_MH:   mul_req = '{a: MUL_A_W'(rmax_sh), b: d_q};
			ST_ML:   mul_req = '{a: MUL_A_W'(rmin_sh), b: d_q};
			ST_CH:   alu_req = '{op: ALU_SUB, a: ALU_W'(hi_q), b: ALU_W'(n_q)};
			ST_CL:   alu_req = '{op: ALU_SUB, a: ALU_W'(n_q), b: ALU_W'(lo_q)};
			ST_ABS:  alu_req = '{op: ALU_SUB, a: '0, b: rem_q};
			ST_DIV:  alu_req = '{op: ALU_SUB, a: rem_q, b: ALU_W'(dsh_q)};
			ST_RCPH: mul_req = '{a: MUL_A_W'(rem_q), b: RCP_HI};
			ST_RCPL: mul_req = '{a: MUL_A_W'(rem_q), b: RCP_LO};
			ST_RCPS: alu_req = '{op: ALU_ADD, a: ALU_W'(n_q) << AVG_SPLIT_W,
				b: ALU_W'(prod)};
			ST_SGN: begin
				if (neg_q) begin
					alu_req = '{op: ALU_SUB, a: '0, b: ALU_W'(q_q)};
				end else begin
					alu_req = '{op: ALU_ADD, a: ALU_W'(q_q), b: '0};
				end
			end
			ST_SUM:  alu_req = '{op: ALU_ADD, a: rem_q, b: ALU_W'(rd_temp)};
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = s_tuser ? ST_UPD : ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_XM;
			ST_XM:   state_d = ST_MN;
			ST_MN:   state_d = ST_MH;
			ST_MH:   state_d = ST_ML;
			ST_ML:   state_d = ST_CH;
			ST_CH:   state_d = ST_CL;
			ST_CL:   state_d = fail_now ? ST_UPD : ST_ABS;
			ST_ABS:  state_d = avg_mode_q ? ST_RCPH : ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SGN;
				end
			end
			ST_RCPH: state_d = ST_RCPL;
			ST_RCPL: state_d = ST_RCPS;
			ST_RCPS: state_d = ST_SGN;
			ST_SGN:  state_d = avg_mode_q ? ST_OUT : ST_UPD;
			ST_UPD:  state_d = last_item ? ST_SUM : ST_OUT;
			ST_SUM: begin
				if (sum_done) begin
					state_d = ST_ABS;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ch_q     <= s_tdata[1:0];
			adc_q    <= s_tdata[2 +: ADC_BITS];
			itemp_q  <= s_tdata[2 + ADC_BITS +: TEMP_W];
			fan_q    <= s_tdata[18 + ADC_BITS +: 4];
			onchip_q <= s_tuser;
		end
		unique case (state_q)
			ST_DIFF: d_q <= alu_y[DIF_W-1:0];
			ST_XM:   x_q <= alu_y[DIF_W-1:0];
			ST_MH:   n_q <= prod;
			ST_ML:   hi_q <= prod;
			ST_CH: begin
				lo_q   <= prod;
				okhi_q <= !alu_y[ALU_W-1];
			end
			ST_CL: begin
				fail_q <= fail_now;
				rem_q  <= ALU_W'(n_q);
				dsh_q  <= {d_q[QUO_W-1:0], {(QUO_W-1){1'b0}}};
			end
			ST_ABS: begin
				neg_q  <= rem_q[ALU_W-1];
				rem_q  <= rem_q[ALU_W-1] ? alu_y : rem_q;
				q_q    <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				if (!alu_y[ALU_W-1]) begin
					rem_q <= alu_y;
				end
				q_q    <= {q_q[QUO_W-2:0], !alu_y[ALU_W-1]};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q + STEP_W'(1);
			end
			ST_RCPL: n_q <= prod;
			ST_RCPS: q_q <= alu_y[AVG_FRAC_W +: QUO_W];
			ST_SGN:  quot_q <= alu_y[TEMP_W-1:0];
			ST_UPD: begin
				res_temp_q <= upd_temp;
				res_mark_q <= upd_mark;
				res_oor_q  <= upd_oor;
				rem_q      <= '0;
			end
			ST_SUM:  rem_q <= alu_y;
			default: ;
		endcase
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {avg_reg_q, res_temp_q};
			m_tuser_q <= {round_q, res_oor_q, res_mark_q};
		end
	end

	// configuration, entries, round control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q       <= FS_RESET;
			ooa_q      <= OOA_RESET;
			rmax_q     <= RMAX_RESET;
			rmin_q     <= RMIN_RESET;
			cte_q      <= 1'b0;
			fut_q      <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				store_q[i] <= '0;
			end
			mark_q     <= '0;
			cnt_q      <= '0;
			sum_idx_q  <= '0;
			avg_reg_q  <= AVG_RESET;
			round_q    <= 1'b0;
			avg_mode_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_FULL_SCALE:     fs_q   <= cfg_data[15:0];
					REG_ONE_OVER_ALPHA: ooa_q  <= cfg_data[23:0];
					REG_RANGE_MAX:      rmax_q <= cfg_data[7:0];
					REG_RANGE_MIN:      rmin_q <= cfg_data[7:0];
					REG_CYCLE_TEST:     cte_q  <= cfg_data[0];
					REG_FAN_UNDER_TEST: fut_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: avg_mode_q <= 1'b0;
				ST_SGN: begin
					if (avg_mode_q) begin
						avg_reg_q <= alu_y[TEMP_W-1:0];
					end
				end
				ST_UPD: begin
					if (stored && !frozen) begin
						store_q[ch_idx] <= upd_temp;
						mark_q[ch_idx]  <= upd_mark;
					end
					round_q   <= last_item;
					cnt_q     <= last_item ? '0 : cnt_q + IDX_W'(1);
					sum_idx_q <= '0;
				end
				ST_SUM: begin
					sum_idx_q <= sum_idx_q + IDX_W'(1);
					if (sum_done) begin
						avg_mode_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* rtl/core/rtdavg_chk.sv */
// ----------------------------------------------------------------------------
// rtdavg_chk
// Port-level checks of the RTD converter and averager, bound to the top.
// ----------------------------------------------------------------------------
module rtdavg_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// busy after taking an item
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while item in flight");

	// result fields are always known while offered
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
		else $error("result fields unknown");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind rtd_adc_to_temperature_averager_unit rtdavg_chk u_rtdavg_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RTD temperature converter and averager. Drives
// channel samples over the input stream with random gaps, checks every result
// transfer against a scoreboard that converts and averages on its own, and
// walks the register file through several settings between quiet phases.
// ----------------------------------------------------------------------------
module testbench;
	import rtdavg_pkg::*;

	localparam int CHANNELS    = 4;
	localparam int PHASE_ITEMS = 200;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0]         channel;
		logic [11:0]        adc;
		logic               onchip;
		logic signed [15:0] chip_temp;
		logic [3:0]         fan;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] channel_temp;
		logic               measured;
		logic               out_of_range;
		logic               avg_ready;
		logic signed [15:0] avg_temp;
	} reading_t;

	typedef struct packed {
		logic [15:0]        full_scale;
		logic [23:0]        inv_alpha;
		logic signed [7:0]  limit_hi;
		logic signed [7:0]  limit_lo;
		logic               freeze_on;
		logic [3:0]         fan_sel;
	} setting_t;

	class rtd_average_scoreboard;
		logic [15:0]       full_scale;
		logic [23:0]       inv_alpha;
		logic signed [7:0] limit_hi;
		logic signed [7:0] limit_lo;
		logic              freeze_on;
		logic [3:0]        fan_sel;
		shortint           channel_temps[CHANNELS];
		bit                measured_flags[CHANNELS];
		int                round_count;
		shortint           running_average;
		reading_t          pending_readings[$];
		int                mismatches;

		function new();
			full_scale = FS_RESET;
			inv_alpha = OOA_RESET;
			limit_hi = RMAX_RESET;
			limit_lo = RMIN_RESET;
			freeze_on = 1'b0;
			fan_sel = 4'd0;
			foreach (channel_temps[i]) begin
				channel_temps[i] = 0;
				measured_flags[i] = 1'b0;
			end
			round_count = 0;
			running_average = AVG_RESET;
			mismatches = 0;
		endfunction

		function void set_register(cfg_reg_t idx, logic [23:0] value);
			case (idx)
				REG_FULL_SCALE:     full_scale = value[15:0];
				REG_ONE_OVER_ALPHA: inv_alpha = value;
				REG_RANGE_MAX:      limit_hi = value[7:0];
				REG_RANGE_MIN:      limit_lo = value[7:0];
				REG_CYCLE_TEST:     freeze_on = value[0];
				REG_FAN_UNDER_TEST: fan_sel = value[3:0];
				default: ;
			endcase
		endfunction

		// count that converts to roughly the given whole degrees
		function int adc_for_degrees(int deg);
			longint scaled;
			longint den;
			longint cnt;
			scaled = longint'(deg) * 256;
			den = 2 * longint'(inv_alpha) + scaled;
			if (den == 0)
				cnt = longint'(full_scale) / 2;
			else
				cnt = longint'(full_scale) * (longint'(inv_alpha) + scaled) / den;
			if (cnt < 0)
				cnt = 0;
			if (cnt > 4095)
				cnt = 4095;
			return int'(cnt);
		endfunction

		function void accept_sample(sample_t s);
			reading_t want;
			longint   fsl;
			longint   diff;
			longint   numer;
			longint   bound_hi;
			longint   bound_lo;
			bit       failed;
			bit       frozen;
			int       sum;
			want = '0;
			frozen = 1'b0;
			if (s.onchip) begin
				want.channel_temp = s.chip_temp;
				want.measured = 1'b0;
			end else begin
				fsl = longint'(full_scale);
				diff = fsl - longint'(s.adc);
				failed = 1'b1;
				if (diff > 0) begin
					numer = longint'(inv_alpha) * (2 * longint'(s.adc) - fsl);
					bound_hi = longint'(limit_hi) * 256 * diff;
					bound_lo = longint'(limit_lo) * 256 * diff;
					if (numer <= bound_hi && numer >= bound_lo) begin
						failed = 1'b0;
						want.channel_temp = 16'(numer / diff);
						want.measured = 1'b1;
					end
				end
				if (failed) begin
					want.out_of_range = 1'b1;
					want.channel_temp = s.chip_temp;
					want.measured = 1'b0;
				end
				frozen = freeze_on && fan_sel != 4'd0 && s.fan == fan_sel - 4'd1;
			end
			if (frozen) begin
				want.channel_temp = channel_temps[s.channel];
				want.measured = measured_flags[s.channel];
			end else begin
				channel_temps[s.channel] = want.channel_temp;
				measured_flags[s.channel] = want.measured;
			end
			round_count++;
			if (round_count >= CHANNELS) begin
				sum = 0;
				foreach (channel_temps[i])
					sum += channel_temps[i];
				running_average = shortint'(sum / CHANNELS);
				round_count = 0;
				want.avg_ready = 1'b1;
			end
			want.avg_temp = running_average;
			pending_readings.push_back(want);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t ns: %s", $time, what);
			mismatches++;
		endtask

		task check_reading(reading_t got);
			reading_t want;
			if (pending_readings.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
				return;
			end
			want = pending_readings.pop_front();
			if (got.channel_temp !== want.channel_temp)
				report_mismatch($sformatf("channel_temp got %0d expected %0d",
					got.channel_temp, want.channel_temp));
			if (got.measured !== want.measured)
				report_mismatch($sformatf("measured got %b expected %b",
					got.measured, want.measured));
			if (got.out_of_range !== want.out_of_range)
				report_mismatch($sformatf("out_of_range got %b expected %b",
					got.out_of_range, want.out_of_range));
			if (got.avg_ready !== want.avg_ready)
				report_mismatch($sformatf("average_ready got %b expected %b",
					got.avg_ready, want.avg_ready));
			if (got.avg_temp !== want.avg_temp)
				report_mismatch($sformatf("average_temp got %0d expected %0d",
					got.avg_temp, want.avg_temp));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// channel_index, adc_count, onchip_temp, fan_index, zero pad
	logic [39:0]          s_tdata;
	// is_onchip
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// channel_temp, average_temp
	logic [31:0]          m_tdata;
	// measured, out_of_range, average_ready
	logic [2:0]           m_tuser;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rtd_average_scoreboard sb;
	bit                    steady_flow = 1'b0;
	int                    cycle_count = 0;

	rtd_adc_to_temperature_averager_unit #(
		.NUM_CHANNELS(CHANNELS),
		.ADC_BITS    (12)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rtd_adc_to_temperature_averager_unit: FAILED **");
			$finish;
		end
	end

	function automatic sample_t make_sample(int ch, int adc, bit onchip, int chip, int fan);
		sample_t s;
		s.channel = 2'(ch);
		s.adc = 12'(adc);
		s.onchip = onchip;
		s.chip_temp = 16'(chip);
		s.fan = 4'(fan);
		return s;
	endfunction

	function automatic setting_t make_setting(int fs, int ooa, int hi, int lo, bit fz, int fan);
		setting_t st;
		st.full_scale = 16'(fs);
		st.inv_alpha = 24'(ooa);
		st.limit_hi = 8'(hi);
		st.limit_lo = 8'(lo);
		st.freeze_on = fz;
		st.fan_sel = 4'(fan);
		return st;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int      pick;
		int      lo;
		int      hi;
		int      cnt;
		s = '0;
		s.channel = 2'($urandom_range(0, 3));
		s.chip_temp = 16'($urandom);
		s.fan = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			s.onchip = 1'b1;
			s.adc = 12'($urandom);
		end else if (pick < 75) begin
			lo = (sb.limit_lo < sb.limit_hi) ? int'(sb.limit_lo) : int'(sb.limit_hi);
			hi = (sb.limit_lo < sb.limit_hi) ? int'(sb.limit_hi) : int'(sb.limit_lo);
			lo = lo - 3;
			hi = hi + 3;
			cnt = sb.adc_for_degrees(lo + int'($urandom_range(0, hi - lo)));
			cnt = cnt + int'($urandom_range(0, 4)) - 2;
			if (cnt < 0)
				cnt = 0;
			if (cnt > 4095)
				cnt = 4095;
			s.adc = 12'(cnt);
		end else begin
			s.adc = 12'($urandom);
		end
		if (sb.freeze_on && sb.fan_sel != 4'd0 && $urandom_range(0, 3) == 0)
			s.fan = sb.fan_sel - 4'd1;
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, s.fan, s.chip_temp, s.adc, s.channel};
		s_tuser <= s.onchip;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.accept_sample(s);
	endtask

	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (sb.pending_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [23:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic load_settings(input setting_t st);
		write_register(REG_FULL_SCALE, 24'(st.full_scale));
		write_register(REG_ONE_OVER_ALPHA, st.inv_alpha);
		write_register(REG_RANGE_MAX, 24'(st.limit_hi));
		write_register(REG_RANGE_MIN, 24'(st.limit_lo));
		write_register(REG_CYCLE_TEST, 24'(st.freeze_on));
		write_register(REG_FAN_UNDER_TEST, 24'(st.fan_sel));
		cfg_we <= 1'b0;
	endtask

	// result side
	initial begin
		int       stall;
		reading_t got;
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.channel_temp = m_tdata[15:0];
			got.avg_temp = m_tdata[31:16];
			got.measured = m_tuser[0];
			got.out_of_range = m_tuser[1];
			got.avg_ready = m_tuser[2];
			sb.check_reading(got);
		end
	end

	// stimulus
	initial begin
		setting_t phases[7];
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FULL_SCALE;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: field extremes and range edges
		send_sample(make_sample(0, 0, 0, 100, 0));
		send_sample(make_sample(1, 4095, 0, -100, 7));
		send_sample(make_sample(2, 2048, 0, 0, 15));
		send_sample(make_sample(3, 1000, 1, 32767, 0));
		send_sample(make_sample(0, 4095, 1, -32768, 15));
		send_sample(make_sample(1, sb.adc_for_degrees(100), 0, 5, 3));
		send_sample(make_sample(2, sb.adc_for_degrees(100) + 1, 0, 6, 4));
		send_sample(make_sample(3, sb.adc_for_degrees(-40), 0, 7, 5));
		send_sample(make_sample(0, sb.adc_for_degrees(-40) - 1, 0, 8, 6));
		drain_block();

		// freeze of fan 0, conversion failures with divider at or past full scale
		load_settings(make_setting(4000, 66496, 100, -40, 1'b1, 1));
		send_sample(make_sample(1, 4095, 0, 1234, 0));
		send_sample(make_sample(2, sb.adc_for_degrees(25), 0, 55, 0));
		send_sample(make_sample(3, 123, 1, -2560, 0));
		send_sample(make_sample(0, sb.adc_for_degrees(25), 0, 66, 1));
		send_sample(make_sample(1, 4000, 0, 77, 2));
		drain_block();

		// inverted range, cycle test with no fan selected
		load_settings(make_setting(4096, 66496, -5, 5, 1'b1, 0));
		send_sample(make_sample(2, 2048, 0, 11, 15));
		send_sample(make_sample(3, 2100, 0, 22, 0));
		send_sample(make_sample(0, 2000, 0, 33, 0));
		send_sample(make_sample(1, 4095, 1, 44, 0));
		drain_block();

		phases[0] = make_setting(4096, 66496, 100, -40, 1'b0, 0);
		phases[1] = make_setting(65535, 16777215, 127, -128, 1'b1, 15);
		phases[2] = make_setting(1, 0, -128, -128, 1'b1, 1);
		phases[3] = make_setting(4095, 1, 127, -128, 1'b0, 4);
		phases[4] = make_setting(3000, 300000, -10, 20, 1'b1, 0);
		phases[5] = make_setting(4096, 0, 0, 0, 1'b1, 8);
		phases[6] = make_setting($urandom_range(2000, 5000), $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 255), $urandom_range(0, 255), 1'b1, $urandom_range(1, 15));

		foreach (phases[p]) begin
			load_settings(phases[p]);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 59) == 0)
					steady_flow = !steady_flow;
				send_sample(random_sample());
			end
			drain_block();
		end

		repeat (60) @(posedge clk);
		if (sb.pending_readings.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived",
				sb.pending_readings.size()));
		if (sb.mismatches == 0) begin
			$display("** rtd_adc_to_temperature_averager_unit: PASSED **");
		end else begin
			$display("** rtd_adc_to_temperature_averager_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* rtd_adc_to_temperature_averager_unit.f */
rtl/core/rtdavg_pkg.sv
rtl/core/rtdavg_alu.sv
rtl/core/rtdavg_mul.sv
rtl/core/rtd_adc_to_temperature_averager_unit.sv
rtl/core/rtdavg_chk.sv
test/testbench.sv
